// File: src/selective_repeat_receiver_macros.svh
// ----------------------------------------------------------------------------
// selective_repeat_receiver_macros
// assertion macros for the selective repeat receiver
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// shared constants, types and helpers of the selective repeat receiver
// ----------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int MAX_PAYLOAD = 500;
    localparam int HEADER_SIZE = 12;

    localparam int SEQ_W    = 32;
    localparam int PLEN_W   = 10;
    localparam int PAY_W    = 9;
    localparam int HANDLE_W = 16;
    localparam int WIN_W    = 6;
    localparam int SLOT_W   = $clog2(WINDOW_MAX);
    localparam int TRIAL_W  = WIN_W + 1;
    localparam int CNT_W    = $clog2(SEQ_W);
    localparam int ENTRY_W  = PAY_W + HANDLE_W;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // remainder unit status
    typedef struct packed {
        logic busy;
        logic done;
    } modw_status_t;

    // window register as used: zero acts as one, large values saturate
    function automatic logic [WIN_W-1:0] active_window(input logic [WIN_W-1:0] raw);
        logic [WIN_W-1:0] w;
        w = raw;
        if (raw == '0)
        begin
            w = WIN_W'(1);
        end
        else if (raw > WIN_W'(WINDOW_MAX))
        begin
            w = WIN_W'(WINDOW_MAX);
        end
        return w;
    endfunction

    // payload byte count from total length, clipped at both ends
    function automatic logic [PAY_W-1:0] payload_bytes(input logic [PLEN_W-1:0] plen);
        logic [PLEN_W-1:0] p;
        p = '0;
        if (plen >= PLEN_W'(HEADER_SIZE))
        begin
            p = plen - PLEN_W'(HEADER_SIZE);
        end
        if (p > PLEN_W'(MAX_PAYLOAD))
        begin
            p = PLEN_W'(MAX_PAYLOAD);
        end
        return p[PAY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/srr_modw.sv
// ----------------------------------------------------------------------------
// srr_modw
// bit-serial remainder of a sequence number by the receive window
// ----------------------------------------------------------------------------
`default_nettype none

module srr_modw
    import srr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SEQ_W-1:0]  dividend,
    input  wire logic [WIN_W-1:0]  divisor,
    output modw_status_t           status,
    output logic      [SLOT_W-1:0] remainder
);

    logic [SLOT_W-1:0]  rem_reg;
    logic [SEQ_W-1:0]   dvd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [TRIAL_W-1:0] trial;
    logic [SLOT_W-1:0]  rem_next;

    // one restoring step per cycle, msb first
    always_comb
    begin
        trial    = TRIAL_W'({rem_reg, dvd_reg[SEQ_W-1]});
        rem_next = trial[SLOT_W-1:0];
        if (trial >= TRIAL_W'(divisor))
        begin
            rem_next = SLOT_W'(trial - TRIAL_W'(divisor));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(SEQ_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[SEQ_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

// File: src/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// receive window of a selective repeat transport: stores in-window packets
// and releases them in sequence order, followed by a cumulative ack
// ----------------------------------------------------------------------------
//
//  channel   | handshake             | carries
//  ----------+-----------------------+------------------------------------------
//  packet in | start / busy          | seq_number, packet_length, payload_handle
//  window    | cfg_valid / cfg_ready | cfg_data (window size)
//  result    | result_valid (strobe) | result_kind, delivered_*, ack_number,
//            |                       | last_of_run
//
//  a request is accepted, then window-checked and written to its slot; a
//  stored packet then releases each in-order packet in turn, and a last step
//  ends the run and sends the ack when anything was delivered
//  a window write keeps busy high while the 32-step remainder unit works
//  out the slot of next_expected under the new window
//  reset is asynchronous; valid bits clear at once, so there is no clear pass
//  results are strobed for one cycle; the receiver cannot stall them
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receiver
    import srr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // packet request
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [SEQ_W-1:0]    seq_number,
    input  wire logic [PLEN_W-1:0]   packet_length,
    input  wire logic [HANDLE_W-1:0] payload_handle,
    // window register write
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [WIN_W-1:0]    cfg_data,
    // results
    output logic                     result_valid,
    output logic                     result_kind,
    output logic      [SEQ_W-1:0]    delivered_seq,
    output logic      [PAY_W-1:0]    delivered_length,
    output logic      [HANDLE_W-1:0] delivered_handle,
    output logic      [SEQ_W-1:0]    ack_number,
    output logic                     last_of_run
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_DRAIN
    } state_t;

    state_t state_reg;

    // architectural state
    logic [WIN_W-1:0]      window_reg;
    logic [SEQ_W-1:0]      ne_reg;       // next expected sequence number
    logic [SLOT_W-1:0]     ne_slot_reg;  // next expected mod window
    logic [WINDOW_MAX-1:0] valid_reg;

    // captured request
    logic [SEQ_W-1:0]    in_seq_reg;
    logic [PAY_W-1:0]    in_pay_reg;
    logic [HANDLE_W-1:0] in_handle_reg;
    logic                drained_reg;    // at least one delivery this request

    // result register
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [SEQ_W-1:0]    out_ack_reg;
    logic                out_last_reg;
    logic                out_use_ram_reg;

    logic [WIN_W-1:0]    w_eff;
    logic                cfg_fire;
    logic                start_fire;

    // window check
    logic [SEQ_W:0]      diff;
    logic                below;
    logic                in_window;
    logic [TRIAL_W-1:0]  slot_sum;
    logic [SLOT_W-1:0]   wr_slot;

    // drain step
    logic                head_valid;
    logic [TRIAL_W-1:0]  slot_inc;
    logic [SLOT_W-1:0]   ne_slot_adv;

    // slot memory and remainder unit
    logic                ram_we;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    modw_status_t        mod_status;
    logic [SLOT_W-1:0]   mod_rem;

    assign w_eff      = active_window(window_reg);
    assign cfg_ready  = (state_reg == ST_IDLE) || (state_reg == ST_MOD);
    assign cfg_fire   = cfg_valid && cfg_ready;
    // a pending window write holds off packets in the same cycle
    assign busy       = (state_reg != ST_IDLE) || cfg_valid;
    assign start_fire = start && !busy;

    always_comb
    begin
        diff      = {1'b0, in_seq_reg} - {1'b0, ne_reg};
        below     = diff[SEQ_W];
        in_window = !below && (diff[SEQ_W-1:0] < SEQ_W'(w_eff));
        // offset is below the window, so one conditional subtract wraps it
        slot_sum  = TRIAL_W'(ne_slot_reg) + TRIAL_W'(diff[WIN_W-1:0]);
        if (slot_sum >= TRIAL_W'(w_eff))
        begin
            slot_sum = slot_sum - TRIAL_W'(w_eff);
        end
        wr_slot   = slot_sum[SLOT_W-1:0];
    end

    always_comb
    begin
        head_valid = valid_reg[ne_slot_reg];
        slot_inc   = TRIAL_W'(ne_slot_reg) + TRIAL_W'(1);
        if (ne_reg == '1)
        begin
            // counter wraps to zero, which is slot zero for any window
            ne_slot_adv = '0;
        end
        else if (slot_inc >= TRIAL_W'(w_eff))
        begin
            ne_slot_adv = '0;
        end
        else
        begin
            ne_slot_adv = slot_inc[SLOT_W-1:0];
        end
    end

    assign ram_we    = (state_reg == ST_CHECK) && in_window;
    assign ram_wdata = {in_pay_reg, in_handle_reg};
    assign ram_re    = (state_reg == ST_DRAIN) && head_valid;

    srr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_MAX)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_slot),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ne_slot_reg),
        .rdata (ram_rdata)
    );

    // restart on every window write; the new window is in place next cycle
    srr_modw u_modw (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_fire),
        .dividend  (ne_reg),
        .divisor   (w_eff),
        .status    (mod_status),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WIN_W'(1);
            ne_reg        <= SEQ_W'(1);
            ne_slot_reg   <= '0;
            valid_reg     <= '0;
            drained_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_DELIVER;
            out_seq_reg   <= '0;
            out_ack_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    priority if (cfg_fire)
                    begin
                        window_reg <= cfg_data;
                        state_reg  <= ST_MOD;
                    end
                    else if (start_fire)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_MOD:
                begin
                    priority if (cfg_fire)
                    begin
                        window_reg <= cfg_data;
                    end
                    else if (mod_status.done)
                    begin
                        ne_slot_reg <= mod_rem;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_CHECK:
                begin
                    drained_reg <= 1'b0;
                    priority if (below)
                    begin
                        // old packet: ack only
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_ACK;
                        out_ack_reg   <= ne_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else if (in_window)
                    begin
                        valid_reg[wr_slot] <= 1'b1;
                        state_reg          <= ST_DRAIN;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DRAIN:
                begin
                    if (head_valid)
                    begin
                        // data comes out of the ram in the next cycle
                        valid_reg[ne_slot_reg] <= 1'b0;
                        out_valid_reg          <= 1'b1;
                        out_kind_reg           <= KIND_DELIVER;
                        out_seq_reg            <= ne_reg;
                        out_last_reg           <= 1'b0;
                        ne_reg                 <= ne_reg + SEQ_W'(1);
                        ne_slot_reg            <= ne_slot_adv;
                        drained_reg            <= 1'b1;
                    end
                    else
                    begin
                        if (drained_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_kind_reg  <= KIND_ACK;
                            out_ack_reg   <= ne_reg;
                            out_last_reg  <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // request capture and ram select of the result
    always_ff @(posedge clk)
    begin
        if (start_fire)
        begin
            in_seq_reg    <= seq_number;
            in_pay_reg    <= payload_bytes(packet_length);
            in_handle_reg <= payload_handle;
        end
        out_use_ram_reg <= ram_re;
    end

    assign result_valid     = out_valid_reg;
    assign result_kind      = out_kind_reg;
    assign last_of_run      = out_last_reg;
    assign delivered_seq    = (out_kind_reg == KIND_DELIVER) ? out_seq_reg : '0;
    assign ack_number       = (out_kind_reg == KIND_ACK) ? out_ack_reg : '0;
    assign delivered_length = out_use_ram_reg ? ram_rdata[ENTRY_W-1:HANDLE_W] : '0;
    assign delivered_handle = out_use_ram_reg ? ram_rdata[HANDLE_W-1:0] : '0;

`include "selective_repeat_receiver_macros.svh"

    `SRR_ASSERT_NOW(a_slot_in_window, clk, rst_n, (state_reg != ST_MOD), (TRIAL_W'(ne_slot_reg) < TRIAL_W'(w_eff)), "next expected slot outside window")

    `SRR_ASSERT_NEXT(a_delivery_advances, clk, rst_n, ((state_reg == ST_DRAIN) && head_valid), (ne_reg == $past(ne_reg) + SEQ_W'(1)), "delivery did not advance next expected")

    `SRR_ASSERT_NEXT(a_delivery_reads_ram, clk, rst_n, ((state_reg == ST_DRAIN) && head_valid), (result_valid && out_use_ram_reg && (result_kind == KIND_DELIVER)), "delivery strobe without slot read")

    `SRR_ASSERT_NOW(a_ack_closes_run, clk, rst_n, (result_valid && (result_kind == KIND_ACK)), (last_of_run && !out_use_ram_reg), "ack not marked as last of run")

    `SRR_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start_fire, (state_reg == ST_CHECK), "accepted packet not checked")

    `SRR_ASSERT_NOW(a_mod_in_progress, clk, rst_n, (state_reg == ST_MOD), (mod_status.busy || mod_status.done), "remainder unit idle during window update")

endmodule

`default_nettype wire
